// ===== rtl/core/msl_pkg.sv =====
// Shared types, widths and saturation helpers for the monotone slope limiter.
// No dependencies; used by every module in rtl/core.
package msl_pkg;

  localparam int GRID_W  = 32;
  localparam int VALUE_W = 32;
  localparam int SLOPE_W = 48;
  localparam int IDX_W   = 10;
  localparam int CNT_W   = 11;
  localparam int IDX_CAP = 1023;

  // serial multiplier operand widths
  localparam int MUL_AW = 96;
  localparam int MUL_BW = 48;
  // serial divider: remainder width and quotient bits
  localparam int DIV_DW = 83;
  localparam int DIV_QW = 57;

  localparam int NUM_W = 131;
  localparam int DEN_W = 82;

  localparam int MAX_POINTS_DEF = 1024;

  localparam logic [SLOPE_W-1:0] SLOPE_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [SLOPE_W-1:0] SLOPE_MIN = 48'h8000_0000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV1,
    ST_PICK,
    ST_PM,
    ST_PN,
    ST_PD1,
    ST_PD2,
    ST_DIV2,
    ST_EMIT1,
    ST_EMIT2
  } msl_state_t;

  // |v| of a signed slope, as an unsigned 48-bit magnitude
  function automatic logic [SLOPE_W-1:0] mag_slope(input logic [SLOPE_W-1:0] v);
    mag_slope = v[SLOPE_W-1] ? (~v + 1'b1) : v;
  endfunction

  // interval difference: saturate positive to max, negative to min
  function automatic logic [SLOPE_W-1:0] sat_diff(input logic [DIV_QW-1:0] q,
                                                  input logic neg);
    logic [SLOPE_W-1:0] r;
    if (neg) begin
      if (q >= {{(DIV_QW-SLOPE_W){1'b0}}, SLOPE_MIN}) r = SLOPE_MIN;
      else r = ~q[SLOPE_W-1:0] + 1'b1;
    end else begin
      if (q > {{(DIV_QW-SLOPE_W){1'b0}}, SLOPE_MAX}) r = SLOPE_MAX;
      else r = q[SLOPE_W-1:0];
    end
    sat_diff = r;
  endfunction

  // weighted mean: clamp magnitude, then apply sign
  function automatic logic [SLOPE_W-1:0] sat_mean(input logic [DIV_QW-1:0] q,
                                                  input logic neg);
    logic [SLOPE_W-1:0] m;
    if (q > {{(DIV_QW-SLOPE_W){1'b0}}, SLOPE_MAX}) m = SLOPE_MAX;
    else m = q[SLOPE_W-1:0];
    sat_mean = neg ? (~m + 1'b1) : m;
  endfunction

endpackage

// ===== rtl/core/msl_smul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on msl_pkg for default widths.
module msl_smul import msl_pkg::*; #(
  parameter int AW = MUL_AW,
  parameter int BW = MUL_BW
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] product,
  output logic             busy,
  output logic             done
);

  localparam int CW = $clog2(BW + 1);

  logic [AW-1:0]    a_reg;
  logic [AW+BW-1:0] p;
  logic [CW-1:0]    cnt;
  logic [AW:0]      sum;

  // add into the upper half, then shift the pair right
  assign sum     = {1'b0, p[AW+BW-1:BW]} + (p[0] ? {1'b0, a_reg} : {(AW+1){1'b0}});
  assign product = p;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_reg <= a;
        p     <= {{AW{1'b0}}, b};
        cnt   <= CW'(BW);
        busy  <= 1'b1;
      end else if (busy) begin
        p   <= {sum, p[BW-1:1]};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/msl_sdiv.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on msl_pkg for default widths; upper numerator part must be below den.
module msl_sdiv import msl_pkg::*; #(
  parameter int DW = DIV_DW,
  parameter int QW = DIV_QW
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] num_hi,
  input  logic [QW-1:0] num_lo,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quotient,
  output logic          busy,
  output logic          done
);

  localparam int CW = $clog2(QW + 1);

  logic [DW-1:0] rem;
  logic [DW-1:0] d;
  logic [QW-1:0] q;
  logic [CW-1:0] cnt;
  logic [DW:0]   t;
  logic [DW+1:0] diff;
  logic          ge;

  assign t    = {rem, q[QW-1]};
  assign diff = {1'b0, t} - {2'b00, d};
  assign ge   = ~diff[DW+1];
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= num_hi;
        q    <= num_lo;
        d    <= den;
        cnt  <= CW'(QW);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? diff[DW-1:0] : t[DW-1:0];
        q   <= {q[QW-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/monotone_slope_limiter.sv =====
// Top level: shape-preserving (Fritsch-Butland) slopes over one streamed series.
// Depends on msl_pkg, msl_smul (serial multiplier) and msl_sdiv (serial divider).
//
//  channel | dir | tdata (low bit up)                          | tuser      | tlast
//  s_*     | in  | grid_point[31:0], sample_value[63:32]      | -          | series_end
//  m_*     | out | slope[47:0], point_number[57:48], pad zero | grid_error | run_last
//
// The first sample of a series uses neither serial unit. Every later sample
// whose grid point rises runs the shared divider once for its interval
// difference. An interior point whose neighboring differences share a sign,
// with no grid error yet, adds four serial products and a second division.
// Input is taken again as soon as the last result of a sample sits in the
// output register; a stalled m_tready holds the second result of a series end.
// Reset (rst, synchronous) clears the series state and m_tvalid and returns to idle, so s_tready is high.
module monotone_slope_limiter import msl_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // grid_point[31:0], sample_value[63:32]
  input  logic        s_tlast,   // series_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // slope[47:0], point_number[57:48], zero
  output logic        m_tuser,   // grid_error
  output logic        m_tlast    // run_last
);

  // top point number: smaller of MAX_POINTS-1 and the field's range
  localparam int NUM_TOP = ((MAX_POINTS - 1) < IDX_CAP) ? (MAX_POINTS - 1) : IDX_CAP;

  msl_state_t state, state_next;

  // series state
  logic [GRID_W-1:0]  prior_grid;
  logic [VALUE_W-1:0] prior_value;
  logic [GRID_W-1:0]  prior_spacing;
  logic [SLOPE_W-1:0] prior_difference;
  logic [CNT_W-1:0]   points_seen;
  logic               error_sticky;

  // current sample
  logic [GRID_W-1:0]  cur_grid;
  logic [VALUE_W-1:0] cur_value;
  logic               cur_end;
  logic [GRID_W-1:0]  cur_h;
  logic               cur_neg;
  logic [SLOPE_W-1:0] cur_d;
  logic [SLOPE_W-1:0] res_slope;
  logic               res_last;
  logic [NUM_W-1:0]   numr;
  logic [DEN_W-1:0]   den_part;

  // input decode
  logic [GRID_W-1:0]  in_grid;
  logic [VALUE_W-1:0] in_value;
  logic               in_bad;
  logic [GRID_W-1:0]  in_h;
  logic [VALUE_W:0]   in_dv;
  logic [VALUE_W:0]   in_dvmag;

  assign in_grid  = s_tdata[31:0];
  assign in_value = s_tdata[63:32];
  assign in_bad   = (in_grid <= prior_grid);
  assign in_h     = in_bad ? '0 : (in_grid - prior_grid);
  assign in_dv    = {in_value[VALUE_W-1], in_value} - {prior_value[VALUE_W-1], prior_value};
  assign in_dvmag = in_dv[VALUE_W] ? (~in_dv + 1'b1) : in_dv;

  // interior weights
  logic [GRID_W:0]    h_sum;
  logic [GRID_W+2:0]  w_num;
  logic [GRID_W+1:0]  w_d1;
  logic [GRID_W+1:0]  w_d2;
  logic [SLOPE_W-1:0] dm_mag;
  logic [SLOPE_W-1:0] dp_mag;
  logic               same_sign;
  logic [DEN_W:0]     den_full;

  assign h_sum  = {1'b0, prior_spacing} + {1'b0, cur_h};
  assign w_num  = {1'b0, h_sum, 1'b0} + {2'b00, h_sum};
  assign w_d1   = {1'b0, prior_spacing, 1'b0} + {2'b00, cur_h};
  assign w_d2   = {2'b00, prior_spacing} + {1'b0, cur_h, 1'b0};
  assign dm_mag = mag_slope(prior_difference);
  assign dp_mag = mag_slope(cur_d);
  assign same_sign =
      (!prior_difference[SLOPE_W-1] && (prior_difference != '0) &&
       !cur_d[SLOPE_W-1] && (cur_d != '0)) ||
      (prior_difference[SLOPE_W-1] && cur_d[SLOPE_W-1]);

  // shared serial units
  logic                     mul_start, mul_busy, mul_done;
  logic [MUL_AW-1:0]        mul_a;
  logic [MUL_BW-1:0]        mul_b;
  logic [MUL_AW+MUL_BW-1:0] mul_p;
  logic                     div_start, div_busy, div_done;
  logic [DIV_DW-1:0]        div_hi, div_den;
  logic [DIV_QW-1:0]        div_lo, div_q;

  assign den_full = {1'b0, den_part} + {1'b0, mul_p[DEN_W-1:0]};

  msl_smul #(.AW(MUL_AW), .BW(MUL_BW)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .product(mul_p), .busy(mul_busy), .done(mul_done)
  );

  msl_sdiv #(.DW(DIV_DW), .QW(DIV_QW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num_hi(div_hi), .num_lo(div_lo),
    .den(div_den), .quotient(div_q), .busy(div_busy), .done(div_done)
  );

  logic out_free;
  logic in_fire;
  logic emit_now;
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  // a result is loaded into the output register this cycle
  assign emit_now = ((state == ST_EMIT1) || (state == ST_EMIT2)) && out_free;

  // point number of a count, saturated at the top
  function automatic logic [IDX_W-1:0] num_of(input logic [CNT_W-1:0] idx);
    num_of = (idx > CNT_W'(NUM_TOP)) ? IDX_W'(NUM_TOP) : idx[IDX_W-1:0];
  endfunction

  // next state and unit launches
  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    div_hi     = '0;
    div_lo     = {in_dvmag, 24'b0};
    div_den    = {{(DIV_DW-GRID_W){1'b0}}, in_h};
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (points_seen == '0) begin
            if (s_tlast) state_next = ST_EMIT1;
          end else if (in_bad) begin
            state_next = ST_PICK;
          end else begin
            div_start  = 1'b1;
            state_next = ST_DIV1;
          end
        end
      end
      ST_DIV1: if (div_done) state_next = ST_PICK;
      ST_PICK: begin
        if (!error_sticky && points_seen != CNT_W'(1) && same_sign) begin
          mul_start  = 1'b1;
          mul_a      = {{(MUL_AW-SLOPE_W){1'b0}}, dm_mag};
          mul_b      = dp_mag;
          state_next = ST_PM;
        end else begin
          state_next = ST_EMIT1;
        end
      end
      ST_PM: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_a      = mul_p[MUL_AW-1:0];
          mul_b      = {{(MUL_BW-GRID_W-3){1'b0}}, w_num};
          state_next = ST_PN;
        end
      end
      ST_PN: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_a      = {{(MUL_AW-SLOPE_W){1'b0}}, dm_mag};
          mul_b      = {{(MUL_BW-GRID_W-2){1'b0}}, w_d1};
          state_next = ST_PD1;
        end
      end
      ST_PD1: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_a      = {{(MUL_AW-SLOPE_W){1'b0}}, dp_mag};
          mul_b      = {{(MUL_BW-GRID_W-2){1'b0}}, w_d2};
          state_next = ST_PD2;
        end
      end
      ST_PD2: begin
        if (mul_done) begin
          if (den_full == '0) begin
            state_next = ST_EMIT1;
          end else begin
            div_start  = 1'b1;
            div_hi     = {{(DIV_DW-(NUM_W-DIV_QW)){1'b0}}, numr[NUM_W-1:DIV_QW]};
            div_lo     = numr[DIV_QW-1:0];
            div_den    = den_full;
            state_next = ST_DIV2;
          end
        end
      end
      ST_DIV2: if (div_done) state_next = ST_EMIT1;
      ST_EMIT1: begin
        if (out_free) state_next = (!res_last && cur_end) ? ST_EMIT2 : ST_IDLE;
      end
      ST_EMIT2: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath and series state
  always_ff @(posedge clk) begin
    if (rst) begin
      prior_grid       <= '0;
      prior_value      <= '0;
      prior_spacing    <= '0;
      prior_difference <= '0;
      points_seen      <= '0;
      error_sticky     <= 1'b0;
      m_tvalid         <= 1'b0;
    end else begin
      if (emit_now) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            cur_grid  <= in_grid;
            cur_value <= in_value;
            cur_end   <= s_tlast;
            cur_h     <= in_h;
            cur_neg   <= in_dv[VALUE_W];
            cur_d     <= '0;
            res_slope <= '0;
            if (points_seen == '0) begin
              res_last <= s_tlast;
              if (!s_tlast) begin
                prior_grid  <= in_grid;
                prior_value <= in_value;
                points_seen <= CNT_W'(1);
              end
            end else begin
              res_last <= 1'b0;
              if (in_bad) error_sticky <= 1'b1;
            end
          end
        end
        ST_DIV1: if (div_done) cur_d <= sat_diff(div_q, cur_neg);
        ST_PICK: begin
          if (!error_sticky && points_seen == CNT_W'(1)) res_slope <= cur_d;
        end
        ST_PM: ;
        ST_PN: if (mul_done) numr <= mul_p[NUM_W-1:0];
        ST_PD1: if (mul_done) den_part <= mul_p[DEN_W-1:0];
        ST_PD2: ;
        ST_DIV2: begin
          if (div_done) res_slope <= sat_mean(div_q, prior_difference[SLOPE_W-1]);
        end
        ST_EMIT1: begin
          if (out_free) begin
            m_tdata  <= {6'b0,
                         res_last ? {IDX_W{1'b0}} : num_of(points_seen - 1'b1),
                         res_slope};
            m_tuser  <= error_sticky;
            m_tlast  <= res_last;
            if (res_last) begin
              points_seen <= '0;
            end else if (!cur_end) begin
              prior_grid       <= cur_grid;
              prior_value      <= cur_value;
              prior_spacing    <= cur_h;
              prior_difference <= cur_d;
              if (points_seen <= CNT_W'(NUM_TOP)) points_seen <= points_seen + 1'b1;
            end
          end
        end
        ST_EMIT2: begin
          if (out_free) begin
            m_tdata  <= {6'b0, num_of(points_seen), error_sticky ? {SLOPE_W{1'b0}} : cur_d};
            m_tuser  <= error_sticky;
            m_tlast  <= 1'b1;
            // series done: back to the reset state
            prior_grid       <= '0;
            prior_value      <= '0;
            prior_spacing    <= '0;
            prior_difference <= '0;
            points_seen      <= '0;
            error_sticky     <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    points_seen <= CNT_W'(NUM_TOP + 1))
    else $error("point count beyond saturation");

  a_err_in_series: assert property (@(posedge clk) disable iff (rst)
    error_sticky |-> points_seen != '0)
    else $error("grid error held outside a series");

  a_units_idle: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !mul_busy && !div_busy)
    else $error("serial unit busy while taking input");

  a_first_point: assert property (@(posedge clk) disable iff (rst)
    in_fire && points_seen == '0 && !s_tlast |=> points_seen == CNT_W'(1))
    else $error("first sample not recorded");
`endif

endmodule
